@@ design/sacl_pkg.sv @@
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared commands, register indexes and controller/datapath interface types
// of the set-associative cache tag directory.
// ----------------------------------------------------------------------------
package sacl_pkg;

  localparam logic [1:0] CMD_PROBE  = 2'd0;
  localparam logic [1:0] CMD_ACCESS = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 5;
  localparam int PROF_SEL_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_PROF_EN  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROF_SEL = 1'd1;

  typedef struct packed {
    logic cap;
    logic mod_step;
    logic rd;
    logic cmp;
    logic vic_init;
    logic vic_step;
    logic row_wr;
    logic fin;
    logic clr_wr;
  } ctrl_cmd_t;

  typedef struct packed {
    logic set_ready;
    logic clr_last;
    logic is_lookup;
    logic is_access;
    logic hit;
    logic vic_last;
    logic out_busy;
  } dp_stat_t;

endpackage

@@ design/sacl_ctrl.sv @@
// ----------------------------------------------------------------------------
// sacl_ctrl
// Controller of the tag directory: clearing sweep after reset, set index,
// directory read, hit check, victim scan, row write-back and result hand-off.
// ----------------------------------------------------------------------------
module sacl_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sacl_pkg::dp_stat_t  stat_i,
  output sacl_pkg::ctrl_cmd_t cmd_o
);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_MOD  = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_VIC  = 3'd4;
  localparam logic [2:0] S_WR   = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLR: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = S_MOD;
        end
      end
      S_MOD: begin
        if (stat_i.set_ready) begin
          cmd_o.rd = 1'b1;
          state_d  = S_CMP;
        end else begin
          cmd_o.mod_step = 1'b1;
        end
      end
      S_CMP: begin
        if (!stat_i.is_lookup) begin
          state_d = S_FIN;
        end else begin
          cmd_o.cmp = 1'b1;
          if (!stat_i.is_access) begin
            state_d = S_FIN;
          end else if (stat_i.hit) begin
            state_d = S_WR;
          end else begin
            cmd_o.vic_init = 1'b1;
            state_d        = S_VIC;
          end
        end
      end
      S_VIC: begin
        cmd_o.vic_step = 1'b1;
        if (stat_i.vic_last) begin
          state_d = S_WR;
        end
      end
      S_WR: begin
        cmd_o.row_wr = 1'b1;
        state_d      = S_FIN;
      end
      S_FIN: begin
        if (!stat_i.out_busy) begin
          cmd_o.fin = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

@@ design/sacl_dp.sv @@
// ----------------------------------------------------------------------------
// sacl_dp
// Datapath of the tag directory: tag and stamp memories, set index unit,
// parallel tag compare, serial victim scan, profile counters and result
// register.
// ----------------------------------------------------------------------------
module sacl_dp #(
  parameter int OFFSET_BITS   = 4,
  parameter int WAY_BITS      = 2,
  parameter int TOTAL_BLOCKS  = 256,
  parameter int PROFILE_COUNT = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [1:0]                       cmd_i,
  input  logic [31:0]                      byte_address_i,
  input  logic                             prof_en_i,
  input  logic [sacl_pkg::PROF_SEL_W-1:0]  prof_sel_i,
  input  sacl_pkg::ctrl_cmd_t              ctrl_i,
  output sacl_pkg::dp_stat_t               stat_o,
  input  logic                             out_stall_i,
  output logic                             out_valid_o,
  output logic                             hit_o,
  output logic [1:0]                       way_used_o,
  output logic [31:0]                      profile_hits_o,
  output logic [31:0]                      profile_misses_o
);

  localparam int BLK_W     = 32 - OFFSET_BITS;
  localparam int WAYS      = 1 << WAY_BITS;
  localparam int WAY_W     = (WAY_BITS > 0) ? WAY_BITS : 1;
  localparam int RAW_SETS  = TOTAL_BLOCKS >> WAY_BITS;
  localparam int SETS      = (RAW_SETS == 0) ? 1 : RAW_SETS;
  localparam int SET_W     = (SETS > 1) ? $clog2(SETS) : 1;
  localparam bit SETS_POW2 = ((SETS & (SETS - 1)) == 0);
  localparam int PROF_W    = (PROFILE_COUNT > 1) ? $clog2(PROFILE_COUNT) : 1;
  localparam logic [sacl_pkg::PROF_SEL_W:0] PROF_CNT_V =
    (sacl_pkg::PROF_SEL_W + 1)'(PROFILE_COUNT);

  typedef logic [WAYS-1:0][BLK_W-1:0] tag_row_t;
  typedef logic [WAYS-1:0][31:0]      stamp_row_t;

  logic [1:0]       cmd_q;
  logic [BLK_W-1:0] block_q;
  logic [SET_W-1:0] set_idx;
  logic             set_ready;

  tag_row_t   tag_mem   [SETS];
  stamp_row_t stamp_mem [SETS];
  tag_row_t   tag_rd_q, tag_wr;
  stamp_row_t stamp_rd_q, stamp_wr;
  logic             wr_en;
  logic [SET_W-1:0] wr_addr;
  logic [SET_W-1:0] clr_cnt_q;

  logic             is_lookup, is_access;
  logic             hit_c;
  logic [WAY_W-1:0] way_c;
  logic             hit_q;
  logic [WAY_W-1:0] way_q, vic_idx_q;
  logic [31:0]      best_age_q, age, stamp_sel;
  logic [31:0]      access_cnt_q;

  logic [31:0]       prof_tot_q [PROFILE_COUNT];
  logic [31:0]       prof_mis_q [PROFILE_COUNT];
  logic              sel_ok;
  logic [PROF_W-1:0] pidx;
  logic [31:0]       nxt_tot, nxt_mis;

  logic        out_valid_q;
  logic        out_hit_q;
  logic [1:0]  out_way_q;
  logic [31:0] out_hits_q, out_mis_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.cap) begin
      cmd_q   <= cmd_i;
      block_q <= byte_address_i[31:OFFSET_BITS];
    end
  end

  if (SETS_POW2) begin : g_set_mask
    assign set_idx   = (SETS == 1) ? '0 : block_q[SET_W-1:0];
    assign set_ready = 1'b1;
  end else begin : g_set_recip
    // The quotient is the block times a rounded-up reciprocal of the set
    // count; the remainder follows from one multiply and subtract.
    localparam int RCP_SH = BLK_W + $clog2(SETS);
    localparam logic [63:0] RCP_V =
      ((64'd1 << RCP_SH) + 64'(SETS) - 64'd1) / 64'(SETS);
    localparam logic [BLK_W:0] RCP = (BLK_W + 1)'(RCP_V);
    logic [2*BLK_W:0] prod_c, prod_q;
    logic [BLK_W-1:0] quot;
    logic [BLK_W-1:0] back;
    logic [SET_W-1:0] rem_q;
    logic [1:0]       step_q;

    assign prod_c = {{BLK_W{1'b0}}, RCP} * {{(BLK_W + 1){1'b0}}, block_q};
    assign quot   = BLK_W'(prod_q >> RCP_SH);
    assign back   = quot * BLK_W'(SETS);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        step_q <= '0;
      end else if (ctrl_i.cap) begin
        step_q <= '0;
      end else if (ctrl_i.mod_step) begin
        step_q <= step_q + 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctrl_i.mod_step) begin
        if (step_q == 2'd0) begin
          prod_q <= prod_c;
        end else begin
          rem_q <= SET_W'(block_q - back);
        end
      end
    end

    assign set_idx   = rem_q;
    assign set_ready = (step_q == 2'd2);
  end

  assign is_lookup = (cmd_q == sacl_pkg::CMD_PROBE) || (cmd_q == sacl_pkg::CMD_ACCESS);
  assign is_access = (cmd_q == sacl_pkg::CMD_ACCESS);

  always_comb begin
    hit_c = 1'b0;
    way_c = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (tag_rd_q[w] == block_q) begin
        hit_c = 1'b1;
        way_c = WAY_W'(w);
      end
    end
  end

  assign stamp_sel = stamp_rd_q[vic_idx_q];
  assign age = (access_cnt_q >= stamp_sel) ? (access_cnt_q - stamp_sel)
                                           : (stamp_sel - access_cnt_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.cap) begin
      hit_q <= 1'b0;
      way_q <= '0;
    end else if (ctrl_i.cmp) begin
      hit_q <= hit_c;
      way_q <= way_c;
    end else if (ctrl_i.vic_step && (age >= best_age_q)) begin
      way_q <= vic_idx_q;
    end
    if (ctrl_i.vic_init) begin
      vic_idx_q  <= '0;
      best_age_q <= '0;
    end else if (ctrl_i.vic_step) begin
      vic_idx_q <= vic_idx_q + 1'b1;
      if (age >= best_age_q) begin
        best_age_q <= age;
      end
    end
  end

  always_comb begin
    tag_wr   = tag_rd_q;
    stamp_wr = stamp_rd_q;
    if (ctrl_i.clr_wr) begin
      tag_wr   = '0;
      stamp_wr = '0;
    end else begin
      if (!hit_q) begin
        tag_wr[way_q] = block_q;
      end
      stamp_wr[way_q] = access_cnt_q;
    end
  end

  assign wr_en   = ctrl_i.clr_wr | ctrl_i.row_wr;
  assign wr_addr = ctrl_i.clr_wr ? clr_cnt_q : set_idx;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tag_mem[wr_addr]   <= tag_wr;
      stamp_mem[wr_addr] <= stamp_wr;
    end
    if (ctrl_i.rd) begin
      tag_rd_q   <= tag_mem[set_idx];
      stamp_rd_q <= stamp_mem[set_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q    <= '0;
      access_cnt_q <= '0;
    end else begin
      if (ctrl_i.clr_wr) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (ctrl_i.row_wr) begin
        access_cnt_q <= access_cnt_q + 32'd1;
      end
    end
  end

  assign sel_ok = ({1'b0, prof_sel_i} < PROF_CNT_V);
  assign pidx   = prof_sel_i[PROF_W-1:0];

  always_comb begin
    nxt_tot = prof_tot_q[pidx];
    nxt_mis = prof_mis_q[pidx];
    if (is_lookup && prof_en_i) begin
      nxt_tot = nxt_tot + 32'd1;
      if (!hit_q) begin
        nxt_mis = nxt_mis + 32'd1;
      end
    end else if (cmd_q == sacl_pkg::CMD_CLEAR) begin
      nxt_tot = '0;
      nxt_mis = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < PROFILE_COUNT; p++) begin
        prof_tot_q[p] <= '0;
        prof_mis_q[p] <= '0;
      end
    end else if (ctrl_i.fin && sel_ok) begin
      prof_tot_q[pidx] <= nxt_tot;
      prof_mis_q[pidx] <= nxt_mis;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.fin) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.fin) begin
      out_hit_q  <= hit_q;
      out_way_q  <= 2'(way_q);
      out_hits_q <= sel_ok ? (nxt_tot - nxt_mis) : 32'd0;
      out_mis_q  <= sel_ok ? nxt_mis : 32'd0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign hit_o            = out_hit_q;
  assign way_used_o       = out_way_q;
  assign profile_hits_o   = out_hits_q;
  assign profile_misses_o = out_mis_q;

  assign stat_o.set_ready = set_ready;
  assign stat_o.clr_last  = (clr_cnt_q == SET_W'(SETS - 1));
  assign stat_o.is_lookup = is_lookup;
  assign stat_o.is_access = is_access;
  assign stat_o.hit       = hit_c;
  assign stat_o.vic_last  = (vic_idx_q == WAY_W'(WAYS - 1));
  assign stat_o.out_busy  = out_valid_q & out_stall_i;

endmodule

@@ design/set_assoc_cache_tag_lru.sv @@
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lru
// Tag directory of a set-associative cache with least-recently-used
// replacement and per-profile hit and miss counters.
// ----------------------------------------------------------------------------
// One item is in work at a time. Every command runs set index, directory read
// and result hand-off; a probe or access also compares the tags, a hitting
// access adds a row write-back, and a missing access a serial victim scan over
// the stamps of all 2**WAY_BITS ways of the set before the write-back. The
// directory has one row per set, read once per item, written once per access.
// When the set count is not a power of two, the set index comes from a
// multiplication by the reciprocal of the set count, through a product and a
// remainder register. After reset the block clears the tag and stamp memories
// one set per cycle and holds the input stalled until it is done. A finished
// result waits in the output register while the next transfer in is taken.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_lru #(
  parameter int OFFSET_BITS   = 4,
  parameter int WAY_BITS      = 2,
  parameter int TOTAL_BLOCKS  = 256,
  parameter int PROFILE_COUNT = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [sacl_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [sacl_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       cmd_i,
  input  logic [31:0]                      byte_address_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             hit_o,
  output logic [1:0]                       way_used_o,
  output logic [31:0]                      profile_hits_o,
  output logic [31:0]                      profile_misses_o
);

  logic                            prof_en_q;
  logic [sacl_pkg::PROF_SEL_W-1:0] prof_sel_q;
  sacl_pkg::ctrl_cmd_t             ctrl_cmd;
  sacl_pkg::dp_stat_t              dp_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prof_en_q  <= 1'b0;
      prof_sel_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sacl_pkg::CFG_PROF_EN:  prof_en_q  <= cfg_wdata_i[0];
        sacl_pkg::CFG_PROF_SEL: prof_sel_q <= cfg_wdata_i[sacl_pkg::PROF_SEL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  sacl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (dp_stat),
    .cmd_o      (ctrl_cmd)
  );

  sacl_dp #(
    .OFFSET_BITS   (OFFSET_BITS),
    .WAY_BITS      (WAY_BITS),
    .TOTAL_BLOCKS  (TOTAL_BLOCKS),
    .PROFILE_COUNT (PROFILE_COUNT)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd_i),
    .byte_address_i   (byte_address_i),
    .prof_en_i        (prof_en_q),
    .prof_sel_i       (prof_sel_q),
    .ctrl_i           (ctrl_cmd),
    .stat_o           (dp_stat),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .hit_o            (hit_o),
    .way_used_o       (way_used_o),
    .profile_hits_o   (profile_hits_o),
    .profile_misses_o (profile_misses_o)
  );

endmodule

@@ test/set_assoc_cache_tag_lru_tb.sv @@
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lru_tb
// Self-checking testbench for the set-associative cache tag directory. A
// short table of directed lookups comes first, then phases of random
// lookups, each phase under its own profile setting. Every transfer in is
// run through a predictor of the tag, stamp and profile state; every transfer
// out is checked against the oldest expectation, the table's own for typed
// rows. Both sides idle at random; the receiver holds off for a long stretch once.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_lru_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int OFFSET_BITS   = 4;
  localparam int WAY_COUNT     = 4;
  localparam int SET_COUNT     = 64;
  localparam int PROFILE_COUNT = 32;
  localparam int BLOCK_W       = 32 - OFFSET_BITS;
  localparam int SET_W         = 6;
  localparam int TAG_W         = 32 - OFFSET_BITS - SET_W;
  localparam int PHASES        = 8;
  localparam int ITEMS_PER_PHASE = 229;
  localparam int HOLD_CYCLES   = 300;
  localparam int IDLE_LIMIT    = 2000;
  localparam int DRAIN_CYCLES  = 30;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic        hit;
    logic [1:0]  way;
    logic [31:0] hits;
    logic [31:0] misses;
  } dir_result_t;

  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] addr;
    bit          typed;
    dir_result_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [sacl_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [sacl_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic in_valid;
  logic in_stall;
  logic [1:0] cmd;
  logic [31:0] byte_address;
  logic out_valid;
  logic out_stall;
  logic hit;
  logic [1:0] way_used;
  logic [31:0] profile_hits;
  logic [31:0] profile_misses;

  bit cur_typed;
  dir_result_t cur_res;
  bit tx_calm;
  bit rx_calm;
  bit rx_hold_req;

  logic [BLOCK_W-1:0] tag_mem [SET_COUNT][WAY_COUNT];
  logic [31:0] stamp_mem [SET_COUNT][WAY_COUNT];
  logic [31:0] access_count;
  logic [31:0] prof_total [PROFILE_COUNT];
  logic [31:0] prof_miss [PROFILE_COUNT];
  logic prof_en;
  logic [sacl_pkg::PROF_SEL_W-1:0] prof_sel;

  dir_result_t awaited_results[$];
  int mismatch_cnt;
  int idle_cycles;

  wire in_fire  = in_valid && !in_stall;
  wire out_fire = out_valid && !out_stall;

  always #6 clk = ~clk;

  set_assoc_cache_tag_lru u_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .cmd_i            (cmd),
    .byte_address_i   (byte_address),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .hit_o            (hit),
    .way_used_o       (way_used),
    .profile_hits_o   (profile_hits),
    .profile_misses_o (profile_misses)
  );

  function automatic dir_result_t dir_lookup(input logic [1:0] c, input logic [31:0] a);
    logic [BLOCK_W-1:0] blk;
    int set_idx;
    logic [31:0] best_age;
    logic [31:0] age;
    logic sel_ok;
    dir_result_t r;
    blk = a[31:OFFSET_BITS];
    set_idx = int'(blk % SET_COUNT);
    sel_ok = prof_sel < PROFILE_COUNT;
    r = '0;
    if (c == sacl_pkg::CMD_PROBE || c == sacl_pkg::CMD_ACCESS) begin
      for (int w = 0; w < WAY_COUNT; w++) begin
        if (!r.hit && tag_mem[set_idx][w] == blk) begin
          r.hit = 1'b1;
          r.way = w[1:0];
        end
      end
      if (prof_en && sel_ok) begin
        prof_total[prof_sel] += 32'd1;
        if (!r.hit) prof_miss[prof_sel] += 32'd1;
      end
      if (c == sacl_pkg::CMD_ACCESS) begin
        if (!r.hit) begin
          best_age = '0;
          for (int w = 0; w < WAY_COUNT; w++) begin
            age = (access_count >= stamp_mem[set_idx][w]) ?
                  access_count - stamp_mem[set_idx][w] :
                  stamp_mem[set_idx][w] - access_count;
            if (age >= best_age) begin
              best_age = age;
              r.way = w[1:0];
            end
          end
          tag_mem[set_idx][r.way] = blk;
        end
        stamp_mem[set_idx][r.way] = access_count;
        access_count += 32'd1;
      end
    end else if (c == sacl_pkg::CMD_CLEAR && sel_ok) begin
      prof_total[prof_sel] = '0;
      prof_miss[prof_sel] = '0;
    end
    if (sel_ok) begin
      r.hits = prof_total[prof_sel] - prof_miss[prof_sel];
      r.misses = prof_miss[prof_sel];
    end
    return r;
  endfunction

  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  initial begin
    for (int s = 0; s < SET_COUNT; s++) begin
      for (int w = 0; w < WAY_COUNT; w++) begin
        tag_mem[s][w] = '0;
        stamp_mem[s][w] = '0;
      end
    end
    for (int p = 0; p < PROFILE_COUNT; p++) begin
      prof_total[p] = '0;
      prof_miss[p] = '0;
    end
    access_count = '0;
    prof_en = 1'b0;
    prof_sel = '0;
  end

  always @(posedge clk) begin
    dir_result_t got;
    dir_result_t want;
    if (cfg_we) begin
      case (cfg_idx)
        sacl_pkg::CFG_PROF_EN: begin
          prof_en = cfg_wdata[0];
        end
        sacl_pkg::CFG_PROF_SEL: begin
          prof_sel = cfg_wdata[sacl_pkg::PROF_SEL_W-1:0];
        end
        default: ;
      endcase
    end
    if (out_fire) begin
      got = '{hit, way_used, profile_hits, profile_misses};
      if (awaited_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("tb: result with nothing expected: hit=%0d way=%0d hits=%0d misses=%0d",
                   got.hit, got.way, got.hits, got.misses);
      end else begin
        want = awaited_results.pop_front();
        if (got !== want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display({"tb: mismatch exp hit=%0d way=%0d hits=%0d misses=%0d,",
                      " got hit=%0d way=%0d hits=%0d misses=%0d"},
                     want.hit, want.way, want.hits, want.misses,
                     got.hit, got.way, got.hits, got.misses);
        end
      end
    end
    if (in_fire) begin
      want = dir_lookup(cmd, byte_address);
      awaited_results.push_back(cur_typed ? cur_res : want);
    end
  end

  always @(posedge clk) begin
    if (in_fire || out_fire) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        rx_hold_req = 1'b0;
      end else begin
        n = rx_calm ? 0 : pick_idle();
        out_stall = (n != 0);
        if (n > 1) repeat (n - 1) @(negedge clk);
      end
    end
  end

  task automatic send_item(input logic [1:0] c, input logic [31:0] a, input bit typed,
                           input dir_result_t r);
    int gap;
    gap = tx_calm ? 0 : pick_idle();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    cmd = c;
    byte_address = a;
    cur_typed = typed;
    cur_res = r;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic set_profile(input logic en, input logic [sacl_pkg::PROF_SEL_W-1:0] sel);
    @(negedge clk);
    in_valid = 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
    cfg_we = 1'b1;
    cfg_idx = sacl_pkg::CFG_PROF_EN;
    cfg_wdata = {4'($urandom), en};
    @(negedge clk);
    cfg_idx = sacl_pkg::CFG_PROF_SEL;
    cfg_wdata = sel;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  stim_row_t directed_rows [22] = '{
    '{sacl_pkg::CMD_PROBE,  32'h0000_0000, 1'b1, '{1'b1, 2'd0, 32'd1, 32'd0}},
    '{sacl_pkg::CMD_PROBE,  32'hFFFF_FFFF, 1'b1, '{1'b0, 2'd0, 32'd1, 32'd1}},
    '{sacl_pkg::CMD_ACCESS, 32'hFFFF_FFFF, 1'b1, '{1'b0, 2'd3, 32'd1, 32'd2}},
    '{sacl_pkg::CMD_ACCESS, 32'hFFFF_FFF0, 1'b1, '{1'b1, 2'd3, 32'd2, 32'd2}},
    '{sacl_pkg::CMD_CLEAR,  32'h0000_0000, 1'b1, '{1'b0, 2'd0, 32'd0, 32'd0}},
    '{CMD_UNUSED,           32'hFFFF_FFFF, 1'b1, '{1'b0, 2'd0, 32'd0, 32'd0}},
    '{sacl_pkg::CMD_ACCESS, 32'h0000_0000, 1'b0, '0},
    '{sacl_pkg::CMD_ACCESS, 32'h0000_0400, 1'b0, '0},
    '{sacl_pkg::CMD_ACCESS, 32'h0000_0800, 1'b0, '0},
    '{sacl_pkg::CMD_ACCESS, 32'h0000_0C00, 1'b0, '0},
    '{sacl_pkg::CMD_ACCESS, 32'h0000_1000, 1'b0, '0},
    '{sacl_pkg::CMD_PROBE,  32'h0000_0000, 1'b0, '0},
    '{sacl_pkg::CMD_ACCESS, 32'h0000_0400, 1'b0, '0},
    '{sacl_pkg::CMD_ACCESS, 32'h8000_0000, 1'b0, '0},
    '{sacl_pkg::CMD_ACCESS, 32'h7FFF_FFFF, 1'b0, '0},
    '{sacl_pkg::CMD_ACCESS, 32'hAAAA_AAAA, 1'b0, '0},
    '{sacl_pkg::CMD_ACCESS, 32'h5555_5555, 1'b0, '0},
    '{sacl_pkg::CMD_PROBE,  32'h5555_5550, 1'b0, '0},
    '{sacl_pkg::CMD_CLEAR,  32'h0000_0000, 1'b0, '0},
    '{CMD_UNUSED,           32'h1234_5678, 1'b0, '0},
    '{sacl_pkg::CMD_PROBE,  32'h0000_1000, 1'b0, '0},
    '{sacl_pkg::CMD_ACCESS, 32'h0000_000F, 1'b0, '0}
  };

  logic phase_en [PHASES] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
  int phase_sel [PHASES] = '{0, 31, 31, -1, 5, 0, -1, 17};

  initial begin
    logic [1:0] c;
    logic [31:0] a;
    logic [SET_W-1:0] set_part;
    logic [TAG_W-1:0] tag_part;
    int r;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    cmd = sacl_pkg::CMD_PROBE;
    byte_address = '0;
    cur_typed = 1'b0;
    cur_res = '0;
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    rx_hold_req = 1'b0;
    mismatch_cnt = 0;
    idle_cycles = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int p = 0; p < PHASES; p++) begin
      set_profile(phase_en[p], (phase_sel[p] < 0) ? sacl_pkg::PROF_SEL_W'($urandom) :
                  sacl_pkg::PROF_SEL_W'(phase_sel[p]));
      tx_calm = (p == 2 || p == 3 || p == 5);
      rx_calm = (p == 2 || p == 5);
      if (p == 3) rx_hold_req = 1'b1;
      if (p == 0) begin
        foreach (directed_rows[i])
          send_item(directed_rows[i].cmd, directed_rows[i].addr, directed_rows[i].typed,
                    directed_rows[i].res);
      end
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        r = $urandom_range(0, 99);
        if (r < 55) c = sacl_pkg::CMD_ACCESS;
        else if (r < 90) c = sacl_pkg::CMD_PROBE;
        else if (r < 96) c = sacl_pkg::CMD_CLEAR;
        else c = CMD_UNUSED;
        r = $urandom_range(0, 99);
        if (r < 60) begin
          tag_part = TAG_W'($urandom_range(0, 7));
          set_part = SET_W'($urandom_range(0, 3));
          a = {tag_part, set_part, 4'($urandom)};
        end else if (r < 85) begin
          tag_part = TAG_W'($urandom_range(0, 63));
          set_part = SET_W'($urandom_range(0, SET_COUNT - 1));
          a = {tag_part, set_part, 4'($urandom)};
        end else begin
          a = $urandom;
        end
        send_item(c, a, 1'b0, '0);
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && awaited_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
